@@ rtl/i2cme_pkg.sv @@
package i2cme_pkg;

    // Phase of the bus sequence: start (S), data or ack bit (B) and stop (P) steps.
    typedef logic [2:0] t_phase;

    localparam t_phase PH_S0 = 3'd0;
    localparam t_phase PH_S1 = 3'd1;
    localparam t_phase PH_S2 = 3'd2;
    localparam t_phase PH_B0 = 3'd3;
    localparam t_phase PH_B1 = 3'd4;
    localparam t_phase PH_P0 = 3'd5;
    localparam t_phase PH_P1 = 3'd6;
    localparam t_phase PH_P2 = 3'd7;

    // Command codes, also used as the engine mode.
    typedef logic [1:0] t_mode;

    localparam t_mode MODE_IDLE  = 2'd0;
    localparam t_mode MODE_WRITE = 2'd1;
    localparam t_mode MODE_READ  = 2'd2;
    localparam t_mode MODE_STOP  = 2'd3;

    // Bit positions in the latched command flags.
    localparam int FL_START = 0;
    localparam int FL_STOP  = 1;
    localparam int FL_ACK   = 2;

    // Bit counter value of the ack bit, after eight data bits.
    localparam logic [3:0] ACK_BIT = 4'd8;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  bit_index;
        logic [7:0]  shift;
        t_mode       mode;
        logic [2:0]  flags;
        logic        scl;
        logic        sda;
        logic [7:0]  rx;
        logic        ack;
    } t_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  tx_byte;
        logic        with_start;
        logic        with_stop;
        logic        send_ack;
        logic        sda_in;
    } t_req;

    typedef struct packed {
        logic        scl_out;
        logic        sda_out;
        logic        busy_res;
        logic        cmd_taken;
        logic        done_res;
        logic [7:0]  rx_byte;
        logic        ack_ok;
    } t_res;

endpackage

@@ rtl/i2cme_in_if.sv @@
interface i2cme_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  tx_byte;
    logic        with_start;
    logic        with_stop;
    logic        send_ack;
    logic        sda_in;

    modport source (
        output valid, req_type, tx_byte, with_start, with_stop, send_ack, sda_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, tx_byte, with_start, with_stop, send_ack, sda_in,
        output ready
    );
endinterface

@@ rtl/i2cme_out_if.sv @@
interface i2cme_out_if;
    logic        valid;
    logic        ready;
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        cmd_taken;
    logic        done_res;
    logic [7:0]  rx_byte;
    logic        ack_ok;

    modport source (
        output valid, scl_out, sda_out, busy_res, cmd_taken, done_res, rx_byte, ack_ok,
        input  ready
    );
    modport sink (
        input  valid, scl_out, sda_out, busy_res, cmd_taken, done_res, rx_byte, ack_ok,
        output ready
    );
endinterface

@@ rtl/i2cme_step.sv @@
module i2cme_step (
    input  i2cme_pkg::t_state i_state,
    input  i2cme_pkg::t_req   i_req,
    output i2cme_pkg::t_state o_state,
    output i2cme_pkg::t_res   o_res
);
    import i2cme_pkg::*;

    // SDA level for the current data or ack bit.
    function automatic logic bit_level(input t_mode md, input logic [3:0] bi,
                                       input logic [7:0] sh, input logic [2:0] fl);
        logic lvl;
        if (md == MODE_WRITE) begin
            lvl = (bi < ACK_BIT) ? sh[7] : 1'b1;
        end else if (bi < ACK_BIT) begin
            lvl = 1'b1;
        end else begin
            lvl = ~fl[FL_ACK];
        end
        return lvl;
    endfunction

    always_comb begin
        t_state s;
        logic   scl;
        logic   sda;
        logic   busy;
        logic   taken;
        logic   fin;

        s     = i_state;
        scl   = i_state.scl;
        sda   = i_state.sda;
        busy  = 1'b0;
        taken = 1'b0;
        fin   = 1'b0;

        // Take a new command only while idle.
        if (s.mode == MODE_IDLE && i_req.req_type != MODE_IDLE) begin
            s.mode      = i_req.req_type;
            s.flags     = {i_req.send_ack, i_req.with_stop, i_req.with_start};
            s.shift     = (i_req.req_type == MODE_WRITE) ? i_req.tx_byte : 8'd0;
            s.bit_index = 4'd0;
            if (i_req.with_start) begin
                s.phase = PH_S0;
            end else begin
                s.phase = (i_req.req_type == MODE_STOP) ? PH_P0 : PH_B0;
            end
            taken = 1'b1;
        end

        // Advance the bus sequence by one interval.
        if (s.mode != MODE_IDLE) begin
            busy = 1'b1;
            unique case (s.phase)
                PH_S0: begin
                    scl = 1'b1; sda = 1'b1; s.phase = PH_S1;
                end
                PH_S1: begin
                    scl = 1'b1; sda = 1'b0; s.phase = PH_S2;
                end
                PH_S2: begin
                    scl = 1'b0; sda = 1'b0;
                    s.bit_index = 4'd0;
                    s.phase = (s.mode == MODE_STOP) ? PH_P0 : PH_B0;
                end
                PH_B0: begin
                    scl = 1'b0;
                    sda = bit_level(s.mode, s.bit_index, s.shift, s.flags);
                    s.phase = PH_B1;
                end
                PH_B1: begin
                    scl = 1'b1;
                    sda = bit_level(s.mode, s.bit_index, s.shift, s.flags);
                    if (s.bit_index < ACK_BIT) begin
                        if (s.mode == MODE_READ) begin
                            s.shift = {s.shift[6:0], i_req.sda_in};
                            if (s.bit_index == ACK_BIT - 4'd1) begin
                                s.rx = s.shift;
                            end
                        end else begin
                            s.shift = {s.shift[6:0], 1'b0};
                        end
                        s.bit_index = s.bit_index + 4'd1;
                        s.phase     = PH_B0;
                    end else begin
                        if (s.mode == MODE_WRITE) begin
                            s.ack = ~i_req.sda_in;
                        end
                        s.bit_index = 4'd0;
                        if (s.flags[FL_STOP]) begin
                            s.phase = PH_P0;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                end
                PH_P0: begin
                    sda = 1'b0; s.phase = PH_P1;
                end
                PH_P1: begin
                    scl = 1'b1; sda = 1'b0; s.phase = PH_P2;
                end
                default: begin
                    scl = 1'b1; sda = 1'b1; fin = 1'b1;
                end
            endcase

            // SCL is pulled low right after the start, a data bit or an ack bit.
            if (s.phase == PH_B0 || s.phase == PH_P0 || (fin && s.phase == PH_B1)) begin
                s.scl = 1'b0;
            end else begin
                s.scl = scl;
            end
            s.sda = sda;

            if (fin) begin
                s.mode  = MODE_IDLE;
                s.flags = 3'd0;
                s.phase = PH_S0;
            end
        end

        o_state         = s;
        o_res.scl_out   = scl;
        o_res.sda_out   = sda;
        o_res.busy_res  = busy;
        o_res.cmd_taken = taken;
        o_res.done_res  = fin;
        o_res.rx_byte   = s.rx;
        o_res.ack_ok    = s.ack;
    end

endmodule

@@ rtl/i2c_master_byte_engine_top.sv @@
// The result of an item is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle; the state update for a tick is a single
// combinational step between the state register and the result register.
// Input ready drops only while a result is held and the output is stalled.
// Reset (synchronous, active low) idles the engine with SCL and SDA released.
module i2c_master_byte_engine_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    i2cme_in_if.sink        i_req,
    i2cme_out_if.source     o_res
);
    import i2cme_pkg::*;

    t_state r_state;
    t_state n_state;
    t_req   req;
    t_res   n_res;
    t_res   r_res;
    logic   r_out_valid;
    logic   acc;

    // Accept while the result register is empty or being emptied.
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign acc         = i_req.valid && i_req.ready;

    assign req = '{req_type:   i_req.req_type,
                   tx_byte:    i_req.tx_byte,
                   with_start: i_req.with_start,
                   with_stop:  i_req.with_stop,
                   send_ack:   i_req.send_ack,
                   sda_in:     i_req.sda_in};

    // One tick of the engine.
    i2cme_step u_step (
        .i_state (r_state),
        .i_req   (req),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // Engine state and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase     <= PH_S0;
            r_state.bit_index <= 4'd0;
            r_state.shift     <= 8'd0;
            r_state.mode      <= MODE_IDLE;
            r_state.flags     <= 3'd0;
            r_state.scl       <= 1'b1;
            r_state.sda       <= 1'b1;
            r_state.rx        <= 8'd0;
            r_state.ack       <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (acc) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.scl_out   = r_res.scl_out;
    assign o_res.sda_out   = r_res.sda_out;
    assign o_res.busy_res  = r_res.busy_res;
    assign o_res.cmd_taken = r_res.cmd_taken;
    assign o_res.done_res  = r_res.done_res;
    assign o_res.rx_byte   = r_res.rx_byte;
    assign o_res.ack_ok    = r_res.ack_ok;

    // The engine goes idle exactly when a result says done or idle.
    a_idle_matches_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> ((r_state.mode == MODE_IDLE) == (r_res.done_res || !r_res.busy_res)))
        else $error("engine mode disagrees with reported done/busy");

    // A taken command or a completion always belongs to a busy interval.
    a_flags_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_res.cmd_taken || r_res.done_res) |-> r_res.busy_res)
        else $error("taken or done reported outside a busy interval");

    // The bit counter never passes the ack bit.
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bit_index <= ACK_BIT)
        else $error("bit counter out of range");

    // With no held result the input side must be ready.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_req.ready)
        else $error("input stalled with empty result register");

    // An idle engine holds no command flags.
    a_idle_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == MODE_IDLE) |-> (r_state.flags == 3'd0))
        else $error("flags left over in idle");

endmodule
